### rtl/core/nel_pkg.sv
`timescale 1ns / 1ps

package nel_pkg;

   localparam int STORE_DEPTH_DEF = 64;

   localparam int TIME_W = 32;
   localparam int ID_W   = 8;
   localparam int VEL_W  = 8;
   localparam int ENTRY_W = TIME_W + ID_W + VEL_W + 1;

   // command selector carried on req_tuser
   localparam logic [2:0] CMD_NOTE    = 3'd0;
   localparam logic [2:0] CMD_PRESS   = 3'd1;
   localparam logic [2:0] CMD_TICK    = 3'd2;
   localparam logic [2:0] CMD_TR_UP   = 3'd3;
   localparam logic [2:0] CMD_TR_DOWN = 3'd4;
   localparam logic [2:0] CMD_ENABLE  = 3'd5;
   localparam logic [2:0] CMD_DISABLE = 3'd6;

   // transpose wraps to zero on reaching +12 or -12 (5-bit two's complement)
   localparam logic [4:0] TR_WRAP_UP   = 5'd12;
   localparam logic [4:0] TR_WRAP_DOWN = 5'd20;
   localparam logic [4:0] SEMITONES    = 5'd12;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_READY = 2'd1,
      MODE_REC   = 2'd2,
      MODE_PLAY  = 2'd3
   } looper_mode_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_ON      = 2'd1,
      KIND_OFF     = 2'd2,
      KIND_ALL_OFF = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } scan_state_type;

   typedef struct packed {
      logic [TIME_W-1:0] offset;
      logic [ID_W-1:0]   id;
      logic [VEL_W-1:0]  vel;
      logic              on;
   } entry_type;

   // fold a signed transpose (-11..11) into 0..11
   function automatic logic [3:0] fold_tr(input logic [4:0] tr);
      logic [4:0] v;
      v = tr[4] ? (tr + SEMITONES) : tr;
      return v[3:0];
   endfunction

   // (id + folded transpose) mod 12 by compare-subtract steps
   function automatic logic [3:0] pitch_class(input logic [7:0] id, input logic [3:0] tf);
      logic [7:0] r;
      logic [4:0] s;
      r = id;
      if (r >= 8'd192) r = r - 8'd192;
      if (r >= 8'd96)  r = r - 8'd96;
      if (r >= 8'd48)  r = r - 8'd48;
      if (r >= 8'd24)  r = r - 8'd24;
      if (r >= 8'd12)  r = r - 8'd12;
      s = {1'b0, r[3:0]} + {1'b0, tf};
      if (s >= SEMITONES) s = s - SEMITONES;
      return s[3:0];
   endfunction

endpackage

### rtl/core/nel_ram.sv
`timescale 1ns / 1ps

module nel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/note_event_looper_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake            tuser            tdata (lowest bit up)              tlast
// req      in   req_tvalid/tready    command [2:0]    now_us, note_id, velocity, on      -
// rsp      out  rsp_tvalid/tready    out_kind [1:0]   out_note, out_velocity, mode, take  last
//                                                     present, transpose_shown
// Any command other than a tick while playing loads its single result into the output
// register. A tick while playing scans the event memory from replay_pos to event_count - 1
// through the registered read port, one entry per cycle while the result side does not
// stall.
// The event memory has no reset; only entries below event_count are ever read.
// Reset is synchronous and puts the looper in the off mode with transpose zero.
// A stalled result holds the output register; a new transaction is taken only in idle
// and when the output register is empty or being drained in the same cycle.

module note_event_looper_core #(
   parameter int STORE_DEPTH = nel_pkg::STORE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // command
   input  logic [55:0] req_tdata,   // now_us[31:0], note_id[39:32], velocity[47:40],
                                    // note_is_on[48], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // out_kind
   output logic [23:0] rsp_tdata,   // out_note[3:0], out_velocity[11:4], looper_mode[13:12],
                                    // take_present[14], transpose_shown[18:15], zero fill
   output logic        rsp_tlast    // last
);

   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int AW = $clog2(STORE_DEPTH);
   localparam logic [CW-1:0] CNT_MAX = CW'(STORE_DEPTH);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   // request fields
   logic [2:0]  cmd;
   logic [31:0] req_now;
   logic [7:0]  req_id;
   logic [7:0]  req_vel;
   logic        req_on;

   assign cmd     = req_tuser;
   assign req_now = req_tdata[31:0];
   assign req_id  = req_tdata[39:32];
   assign req_vel = req_tdata[47:40];
   assign req_on  = req_tdata[48];

   // control state
   nel_pkg::scan_state_type  state_ff, state_in;
   nel_pkg::looper_mode_type mode_ff, mode_in;
   logic [4:0]    tr_ff, tr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rpos_ff, rpos_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [31:0]   take_start_ff, take_start_in;
   logic [31:0]   loop_start_ff, loop_start_in;
   logic [31:0]   loop_len_ff, loop_len_in;
   logic          has_take_ff, has_take_in;
   logic          pend_valid_ff, pend_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   logic [31:0]        now_ff, now_in;
   nel_pkg::kind_type  pend_kind_ff, pend_kind_in;
   logic [3:0]         pend_note_ff, pend_note_in;
   logic [7:0]         pend_vel_ff, pend_vel_in;
   nel_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   logic [3:0]         rsp_note_ff, rsp_note_in;
   logic [7:0]         rsp_vel_ff, rsp_vel_in;
   logic               rsp_last_ff, rsp_last_in;
   nel_pkg::looper_mode_type rsp_mode_ff, rsp_mode_in;
   logic               rsp_take_ff, rsp_take_in;
   logic [3:0]         rsp_tr_ff, rsp_tr_in;

   // memory port
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   nel_pkg::entry_type         wr_entry;
   logic [AW-1:0]              rd_addr;
   logic [nel_pkg::ENTRY_W-1:0] rd_data;
   nel_pkg::entry_type         rd_entry;

   logic          acc;
   logic          slot_free;
   logic          all_off;
   logic          emit_now;
   logic          rewind;
   logic [CW-1:0] eff_count;
   logic [CW-1:0] scan_start;
   logic [CW-1:0] idx_next;
   logic          adv;
   logic          at_end;
   logic [31:0]   due_time;
   logic          due;
   nel_pkg::kind_type scan_kind;
   logic [3:0]    scan_note;
   logic [7:0]    scan_vel;

   assign rd_entry  = nel_pkg::entry_type'(rd_data);
   assign due_time  = rd_entry.offset + loop_start_ff;
   assign due       = now_ff >= due_time;
   assign at_end    = idx_ff >= count_ff;
   assign idx_next  = idx_ff + CNT_ONE;
   assign scan_kind = rd_entry.on ? nel_pkg::KIND_ON : nel_pkg::KIND_OFF;
   assign scan_note = nel_pkg::pitch_class(rd_entry.id, nel_pkg::fold_tr(tr_ff));
   assign scan_vel  = rd_entry.on ? rd_entry.vel : 8'd0;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == nel_pkg::ST_IDLE) && slot_free;
   assign acc        = req_tvalid && req_tready;
   assign rewind     = (req_now - loop_start_ff) > loop_len_ff;
   assign eff_count  = (mode_ff == nel_pkg::MODE_READY) ? '0 : count_ff;

   nel_ram #(
      .WIDTH (nel_pkg::ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      tr_in         = tr_ff;
      count_in      = count_ff;
      rpos_in       = rpos_ff;
      idx_in        = idx_ff;
      take_start_in = take_start_ff;
      loop_start_in = loop_start_ff;
      loop_len_in   = loop_len_ff;
      has_take_in   = has_take_ff;
      pend_valid_in = pend_valid_ff;
      now_in        = now_ff;
      pend_kind_in  = pend_kind_ff;
      pend_note_in  = pend_note_ff;
      pend_vel_in   = pend_vel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_note_in   = rsp_note_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_mode_in   = rsp_mode_ff;
      rsp_take_in   = rsp_take_ff;
      rsp_tr_in     = rsp_tr_ff;
      wr_en         = 1'b0;
      wr_addr       = eff_count[AW-1:0];
      wr_entry      = '{offset: '0, id: req_id, vel: req_vel, on: req_on};
      all_off       = 1'b0;
      emit_now      = 1'b0;
      adv           = 1'b0;
      scan_start    = rewind ? '0 : rpos_ff;
      rd_addr       = scan_start[AW-1:0];

      case (state_ff)
         nel_pkg::ST_IDLE: begin
            if (acc) begin
               emit_now = 1'b1;
               case (cmd)
                  nel_pkg::CMD_NOTE: begin
                     if (mode_ff == nel_pkg::MODE_READY || mode_ff == nel_pkg::MODE_REC) begin
                        if (mode_ff == nel_pkg::MODE_READY) begin
                           count_in      = '0;
                           take_start_in = '0;
                           loop_len_in   = '0;
                           mode_in       = nel_pkg::MODE_REC;
                        end
                        if (eff_count < CNT_MAX) begin
                           // first event of a take anchors the take start
                           if (eff_count == '0) begin
                              take_start_in = req_now;
                           end else begin
                              wr_entry.offset = req_now - take_start_ff;
                           end
                           wr_en    = 1'b1;
                           count_in = eff_count + CNT_ONE;
                           if (eff_count != '0) begin
                              has_take_in = 1'b1;
                           end
                        end
                     end
                  end
                  nel_pkg::CMD_PRESS: begin
                     case (mode_ff)
                        nel_pkg::MODE_READY: begin
                           mode_in = has_take_ff ? nel_pkg::MODE_PLAY : nel_pkg::MODE_READY;
                        end
                        nel_pkg::MODE_REC: begin
                           loop_len_in = req_now - take_start_ff;
                           mode_in = has_take_ff ? nel_pkg::MODE_PLAY : nel_pkg::MODE_READY;
                        end
                        nel_pkg::MODE_PLAY: begin
                           all_off = 1'b1;
                           mode_in = nel_pkg::MODE_READY;
                        end
                        default: begin
                        end
                     endcase
                  end
                  nel_pkg::CMD_TICK: begin
                     if (mode_ff == nel_pkg::MODE_PLAY) begin
                        // start a new pass once the loop length has run out
                        if (rewind) begin
                           loop_start_in = req_now;
                           rpos_in       = '0;
                        end
                        idx_in   = scan_start;
                        now_in   = req_now;
                        state_in = nel_pkg::ST_SCAN;
                        emit_now = 1'b0;
                     end
                  end
                  nel_pkg::CMD_TR_UP: begin
                     tr_in   = (tr_ff + 5'd1 == nel_pkg::TR_WRAP_UP) ? 5'd0 : tr_ff + 5'd1;
                     all_off = 1'b1;
                  end
                  nel_pkg::CMD_TR_DOWN: begin
                     tr_in   = (tr_ff - 5'd1 == nel_pkg::TR_WRAP_DOWN) ? 5'd0 : tr_ff - 5'd1;
                     all_off = 1'b1;
                  end
                  nel_pkg::CMD_ENABLE: begin
                     mode_in = nel_pkg::MODE_READY;
                  end
                  nel_pkg::CMD_DISABLE: begin
                     all_off = 1'b1;
                     mode_in = nel_pkg::MODE_OFF;
                  end
                  default: begin
                  end
               endcase

               // single result of the transaction, status after the update
               if (emit_now) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = all_off ? nel_pkg::KIND_ALL_OFF : nel_pkg::KIND_NONE;
                  rsp_note_in  = '0;
                  rsp_vel_in   = '0;
                  rsp_last_in  = 1'b1;
                  rsp_mode_in  = mode_in;
                  rsp_take_in  = has_take_in;
                  rsp_tr_in    = nel_pkg::fold_tr(tr_in);
               end
            end
         end

         nel_pkg::ST_SCAN: begin
            // one due entry waits in the pending slot so the final one can carry last
            if (at_end) begin
               if (slot_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = pend_valid_ff ? pend_kind_ff : nel_pkg::KIND_NONE;
                  rsp_note_in   = pend_valid_ff ? pend_note_ff : 4'd0;
                  rsp_vel_in    = pend_valid_ff ? pend_vel_ff : 8'd0;
                  rsp_last_in   = 1'b1;
                  rsp_mode_in   = mode_ff;
                  rsp_take_in   = has_take_ff;
                  rsp_tr_in     = nel_pkg::fold_tr(tr_ff);
                  pend_valid_in = 1'b0;
                  state_in      = nel_pkg::ST_IDLE;
               end
            end else if (!due) begin
               adv = 1'b1;
            end else if (!pend_valid_ff || slot_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = pend_kind_ff;
                  rsp_note_in  = pend_note_ff;
                  rsp_vel_in   = pend_vel_ff;
                  rsp_last_in  = 1'b0;
                  rsp_mode_in  = mode_ff;
                  rsp_take_in  = has_take_ff;
                  rsp_tr_in    = nel_pkg::fold_tr(tr_ff);
               end
               pend_valid_in = 1'b1;
               pend_kind_in  = scan_kind;
               pend_note_in  = scan_note;
               pend_vel_in   = scan_vel;
               rpos_in       = rpos_ff + CNT_ONE;
               adv           = 1'b1;
            end
            // hold the read address while stalled so the data stays on the port
            idx_in  = adv ? idx_next : idx_ff;
            rd_addr = idx_in[AW-1:0];
         end

         default: begin
            state_in = nel_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nel_pkg::ST_IDLE;
         mode_ff       <= nel_pkg::MODE_OFF;
         tr_ff         <= '0;
         count_ff      <= '0;
         rpos_ff       <= '0;
         idx_ff        <= '0;
         take_start_ff <= '0;
         loop_start_ff <= '0;
         loop_len_ff   <= '0;
         has_take_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         tr_ff         <= tr_in;
         count_ff      <= count_in;
         rpos_ff       <= rpos_in;
         idx_ff        <= idx_in;
         take_start_ff <= take_start_in;
         loop_start_ff <= loop_start_in;
         loop_len_ff   <= loop_len_in;
         has_take_ff   <= has_take_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      pend_kind_ff <= pend_kind_in;
      pend_note_ff <= pend_note_in;
      pend_vel_ff  <= pend_vel_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_note_ff  <= rsp_note_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_take_ff  <= rsp_take_in;
      rsp_tr_ff    <= rsp_tr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_tr_ff, rsp_take_ff, rsp_mode_ff, rsp_vel_ff, rsp_note_ff};

`ifndef ASSERT_OFF
   a_pend_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == nel_pkg::ST_IDLE |-> !pend_valid_ff)
      else $error("pending result held outside a scan");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("event count beyond store depth");

   a_transpose_range: assert property (@(posedge clock) disable iff (reset)
      $signed(tr_ff) <= 5'sd11 && $signed(tr_ff) >= -5'sd11)
      else $error("transpose out of range");

   a_scan_ends_with_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == nel_pkg::ST_SCAN && state_in == nel_pkg::ST_IDLE
      |=> rsp_valid_ff && rsp_last_ff)
      else $error("scan finished without a final result");
`endif

endmodule
